### rtl/ddk_pkg.sv
// Shared types, codes and reset values for the differential-drive key command latch.
// No dependencies; every other file of the block imports this package.
package ddk_pkg;

  localparam int unsigned DutyBits  = 8;
  localparam int unsigned SpeedBits = 7;
  localparam int unsigned IntvBits  = 16;
  localparam int unsigned CfgWidth  = 16;
  localparam int unsigned CfgIdxW   = 3;

  // Input operation codes
  localparam logic [1:0] OpKey  = 2'd0;
  localparam logic [1:0] OpTick = 2'd1;
  localparam logic [1:0] OpMove = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgForwardCap  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgTurnCap     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgWatchdog    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgRepeat      = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgInvertLeft  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgInvertRight = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgDefForward  = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgDefTurn     = 3'd7;

  // Configuration reset values
  localparam logic [SpeedBits-1:0] RstForwardCap  = 7'd80;
  localparam logic [SpeedBits-1:0] RstTurnCap     = 7'd80;
  localparam logic [IntvBits-1:0]  RstWatchdog    = 16'd500;
  localparam logic [IntvBits-1:0]  RstRepeat      = 16'd100;
  localparam logic                 RstInvertLeft  = 1'b1;
  localparam logic                 RstInvertRight = 1'b0;
  localparam logic [SpeedBits-1:0] RstDefForward  = 7'd30;
  localparam logic [SpeedBits-1:0] RstDefTurn     = 7'd40;

  localparam logic [SpeedBits-1:0] SpeedStep  = 7'd5;
  localparam logic [SpeedBits-1:0] SpeedFloor = 7'd5;
  localparam logic [SpeedBits-1:0] PctLimit   = 7'd100;

  // duty = a*255/100 as one constant multiply: a * ceil(2^22/100)*255 >> 22,
  // exact for a in 0..100
  localparam int unsigned DutyShift = 22;
  localparam logic [23:0] DutyMul   = 24'd10695720;

  typedef enum logic [2:0] {
    MotNone  = 3'd0,
    MotFwd   = 3'd1,
    MotBack  = 3'd2,
    MotLeft  = 3'd3,
    MotRight = 3'd4
  } motion_e;

  typedef enum logic [3:0] {
    KcNone,
    KcMotion,
    KcStop,
    KcHome,
    KcFwdUp,
    KcFwdDown,
    KcTurnUp,
    KcTurnDown,
    KcPing
  } key_class_e;

  typedef struct packed {
    logic [SpeedBits-1:0] forward_cap;
    logic [SpeedBits-1:0] pivot_cap;
    logic [IntvBits-1:0]  watchdog_ticks;
    logic [IntvBits-1:0]  repeat_ticks;
    logic                 flip_left;
    logic                 flip_right;
    logic [SpeedBits-1:0] default_forward_speed;
    logic [SpeedBits-1:0] default_turn_speed;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [7:0]        key_char;
    logic signed [7:0] move_left;
    logic signed [7:0] move_right;
  } item_t;

  typedef struct packed {
    logic                 left_direction;
    logic [DutyBits-1:0]  left_duty;
    logic                 right_direction;
    logic [DutyBits-1:0]  right_duty;
    logic                 drive_active;
    logic [SpeedBits-1:0] speed_forward;
    logic [SpeedBits-1:0] speed_turn;
    logic [2:0]           latch_code;
    logic                 watchdog_fired;
  } res_t;

  function automatic motion_e motion_of(input logic [7:0] k);
    motion_e m;
    m = MotNone;
    if (k inside {"w", "W", "f", "F"}) m = MotFwd;
    else if (k inside {"s", "S", "b", "B"}) m = MotBack;
    else if (k inside {"a", "A", "l", "L"}) m = MotLeft;
    else if (k inside {"d", "D", "r", "R"}) m = MotRight;
    return m;
  endfunction

  function automatic key_class_e class_of(input logic [7:0] k);
    key_class_e c;
    c = KcNone;
    if (motion_of(k) != MotNone) c = KcMotion;
    else if (k inside {"x", "X", " "}) c = KcStop;
    else if (k inside {"h", "H"}) c = KcHome;
    else if (k inside {"q", "Q"}) c = KcFwdUp;
    else if (k inside {"z", "Z"}) c = KcFwdDown;
    else if (k inside {"e", "E"}) c = KcTurnUp;
    else if (k inside {"c", "C"}) c = KcTurnDown;
    else if (k inside {"v", "V", "?"}) c = KcPing;
    return c;
  endfunction

  // Absolute percent (0..100) scaled to full duty range
  function automatic logic [DutyBits-1:0] duty_of(input logic signed [7:0] p);
    logic [6:0]  a;
    logic [30:0] prod;
    a    = p[7] ? 7'(-p) : p[6:0];
    prod = 31'(a) * 31'(DutyMul);
    return prod[DutyShift +: DutyBits];
  endfunction

endpackage

### rtl/ddk_if.sv
// Valid/ready channel interfaces for command items and result items.
// Depends on ddk_pkg for field widths.
interface ddk_cmd_if
  import ddk_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [7:0]        key_char;
  logic signed [7:0] move_left;
  logic signed [7:0] move_right;

  modport source (output valid, output op, output key_char, output move_left,
                  output move_right, input ready);
  modport sink   (input valid, input op, input key_char, input move_left,
                  input move_right, output ready);
endinterface

interface ddk_res_if
  import ddk_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic                 left_direction;
  logic [DutyBits-1:0]  left_duty;
  logic                 right_direction;
  logic [DutyBits-1:0]  right_duty;
  logic                 drive_active;
  logic [SpeedBits-1:0] speed_forward;
  logic [SpeedBits-1:0] speed_turn;
  logic [2:0]           latch_code;
  logic                 watchdog_fired;

  modport source (output valid, output left_direction, output left_duty,
                  output right_direction, output right_duty, output drive_active,
                  output speed_forward, output speed_turn, output latch_code,
                  output watchdog_fired, input ready);
  modport sink   (input valid, input left_direction, input left_duty,
                  input right_direction, input right_duty, input drive_active,
                  input speed_forward, input speed_turn, input latch_code,
                  input watchdog_fired, output ready);
endinterface

### rtl/ddk_cfg_regs.sv
// Configuration register file of the key command latch.
// Depends on ddk_pkg for cfg_t, register indexes and reset values.
module ddk_cfg_regs
  import ddk_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgWidth-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgForwardCap:  cfg_d.forward_cap           = cfg_data_i[SpeedBits-1:0];
        CfgTurnCap:     cfg_d.pivot_cap             = cfg_data_i[SpeedBits-1:0];
        CfgWatchdog:    cfg_d.watchdog_ticks        = cfg_data_i[IntvBits-1:0];
        CfgRepeat:      cfg_d.repeat_ticks          = cfg_data_i[IntvBits-1:0];
        CfgInvertLeft:  cfg_d.flip_left             = cfg_data_i[0];
        CfgInvertRight: cfg_d.flip_right            = cfg_data_i[0];
        CfgDefForward:  cfg_d.default_forward_speed = cfg_data_i[SpeedBits-1:0];
        CfgDefTurn:     cfg_d.default_turn_speed    = cfg_data_i[SpeedBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.forward_cap           <= RstForwardCap;
      cfg_q.pivot_cap             <= RstTurnCap;
      cfg_q.watchdog_ticks        <= RstWatchdog;
      cfg_q.repeat_ticks          <= RstRepeat;
      cfg_q.flip_left             <= RstInvertLeft;
      cfg_q.flip_right            <= RstInvertRight;
      cfg_q.default_forward_speed <= RstDefForward;
      cfg_q.default_turn_speed    <= RstDefTurn;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/ddk_core.sv
// Drive state and one-item update logic: speeds, latch, timers, wheel percents.
// Depends on ddk_pkg for item, result and configuration types.
module ddk_core
  import ddk_pkg::*;
#(
  parameter int unsigned TIME_BITS = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  step_i,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output res_t  res_o
);

  localparam int unsigned CmpW = (TIME_BITS > IntvBits) ? TIME_BITS : IntvBits;
  localparam logic [TIME_BITS-1:0] TimeMax = '1;

  logic [SpeedBits-1:0] fs_q, fs_d, ps_q, ps_d;
  motion_e              latch_q, latch_d;
  logic [TIME_BITS-1:0] sc_q, sc_d, sr_q, sr_d;
  logic signed [7:0]    lp_q, lp_d, rp_q, rp_d;
  logic                 mov_q, mov_d;
  logic                 fired;

  logic [TIME_BITS-1:0] sc_inc, sr_inc;
  logic [SpeedBits-1:0] f_eff, t_eff, f_pct, t_pct, mv_lim;
  logic [SpeedBits:0]   fs_up, ps_up;
  key_class_e           kc;
  motion_e              key_mot;

  function automatic logic signed [7:0] clamp_move(input logic signed [7:0] v,
                                                   input logic [SpeedBits-1:0] lim);
    logic signed [8:0] v9, l9;
    logic signed [7:0] r;
    v9 = 9'(v);
    l9 = $signed({2'b00, lim});
    if (v9 > l9) r = 8'(l9);
    else if (v9 < -l9) r = 8'(-l9);
    else r = v;
    return r;
  endfunction

  assign sc_inc = (sc_q == TimeMax) ? sc_q : sc_q + 1'b1;
  assign sr_inc = (sr_q == TimeMax) ? sr_q : sr_q + 1'b1;

  assign f_eff  = (fs_q < cfg_i.forward_cap) ? fs_q : cfg_i.forward_cap;
  assign t_eff  = (ps_q < cfg_i.pivot_cap) ? ps_q : cfg_i.pivot_cap;
  // Wheel percents never exceed full scale
  assign f_pct  = (f_eff > PctLimit) ? PctLimit : f_eff;
  assign t_pct  = (t_eff > PctLimit) ? PctLimit : t_eff;
  assign mv_lim = (cfg_i.forward_cap > PctLimit) ? PctLimit : cfg_i.forward_cap;

  assign fs_up = {1'b0, fs_q} + {1'b0, SpeedStep};
  assign ps_up = {1'b0, ps_q} + {1'b0, SpeedStep};

  assign kc      = class_of(item_i.key_char);
  assign key_mot = motion_of(item_i.key_char);

  always_comb begin
    logic    apply;
    motion_e code;
    apply   = 1'b0;
    code    = MotNone;
    fs_d    = fs_q;
    ps_d    = ps_q;
    latch_d = latch_q;
    sc_d    = sc_q;
    sr_d    = sr_q;
    lp_d    = lp_q;
    rp_d    = rp_q;
    mov_d   = mov_q;
    fired   = 1'b0;

    case (item_i.op)
      OpKey: begin
        if (kc != KcNone) sc_d = '0;
        case (kc)
          KcMotion: begin
            latch_d = key_mot;
            sr_d    = '0;
            apply   = 1'b1;
            code    = key_mot;
          end
          KcStop: begin
            lp_d    = '0;
            rp_d    = '0;
            mov_d   = 1'b0;
            latch_d = MotNone;
          end
          KcHome: begin
            lp_d    = '0;
            rp_d    = '0;
            mov_d   = 1'b0;
            latch_d = MotNone;
            fs_d    = cfg_i.default_forward_speed;
            ps_d    = cfg_i.default_turn_speed;
          end
          KcFwdUp:    fs_d = (fs_up < {1'b0, cfg_i.forward_cap}) ? fs_up[SpeedBits-1:0]
                                                                 : cfg_i.forward_cap;
          KcFwdDown:  fs_d = (fs_q > SpeedStep + SpeedFloor) ? fs_q - SpeedStep : SpeedFloor;
          KcTurnUp:   ps_d = (ps_up < {1'b0, cfg_i.pivot_cap}) ? ps_up[SpeedBits-1:0]
                                                               : cfg_i.pivot_cap;
          KcTurnDown: ps_d = (ps_q > SpeedStep + SpeedFloor) ? ps_q - SpeedStep : SpeedFloor;
          default: ;
        endcase
      end
      OpTick: begin
        sc_d = sc_inc;
        sr_d = sr_inc;
        if (latch_q != MotNone && CmpW'(sr_inc) >= CmpW'(cfg_i.repeat_ticks)) begin
          sr_d  = '0;
          apply = 1'b1;
          code  = latch_q;
        end
        if (latch_q == MotNone && mov_q
            && CmpW'(sc_inc) > CmpW'(cfg_i.watchdog_ticks)) begin
          lp_d  = '0;
          rp_d  = '0;
          mov_d = 1'b0;
          fired = 1'b1;
        end
      end
      OpMove: begin
        sc_d    = '0;
        latch_d = MotNone;
        lp_d    = clamp_move(item_i.move_left, mv_lim);
        rp_d    = clamp_move(item_i.move_right, mv_lim);
        mov_d   = (lp_d != '0) || (rp_d != '0);
      end
      default: ;
    endcase

    if (apply) begin
      case (code)
        MotFwd:   begin lp_d = 8'(f_pct);  rp_d = 8'(f_pct);  end
        MotBack:  begin lp_d = -8'(f_pct); rp_d = -8'(f_pct); end
        MotLeft:  begin lp_d = -8'(t_pct); rp_d = 8'(t_pct);  end
        MotRight: begin lp_d = 8'(t_pct);  rp_d = -8'(t_pct); end
        default: ;
      endcase
      if (code != MotNone) mov_d = (lp_d != '0) || (rp_d != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q    <= RstDefForward;
      ps_q    <= RstDefTurn;
      latch_q <= MotNone;
      sc_q    <= '0;
      sr_q    <= '0;
      lp_q    <= '0;
      rp_q    <= '0;
      mov_q   <= 1'b0;
    end else if (step_i) begin
      fs_q    <= fs_d;
      ps_q    <= ps_d;
      latch_q <= latch_d;
      sc_q    <= sc_d;
      sr_q    <= sr_d;
      lp_q    <= lp_d;
      rp_q    <= rp_d;
      mov_q   <= mov_d;
    end
  end

  always_comb begin
    res_o.left_direction  = (~lp_d[7]) ^ cfg_i.flip_left;
    res_o.left_duty       = duty_of(lp_d);
    res_o.right_direction = (~rp_d[7]) ^ cfg_i.flip_right;
    res_o.right_duty      = duty_of(rp_d);
    res_o.drive_active    = mov_d;
    res_o.speed_forward   = fs_d;
    res_o.speed_turn      = ps_d;
    res_o.latch_code      = latch_d;
    res_o.watchdog_fired  = fired;
  end

endmodule

### rtl/diff_drive_key_command_latch.sv
// Top level of the differential-drive key command latch: input register,
// update core, result register and configuration file.
// Depends on ddk_pkg, ddk_if, ddk_cfg_regs and ddk_core.

// The block takes one command transaction per clock cycle while the result
// side is not stalled: a key character, a one-millisecond tick or a direct
// left/right move, and answers each with exactly one result transaction
// carrying both wheel direction bits and 8-bit duties, the drive-active flag,
// the current speeds, the latched motion and a watchdog flag. An accepted
// command is held in the input register, then the state update and duty
// scaling run combinationally between the two registers and the answer lands
// in the result register. The throughput limit is the single update step
// between the two registers; a stalled result register holds the pipe, and
// the input register takes one more command while a result waits only if it
// is empty. Configuration writes take effect on the next edge and should be
// made only while no command is in flight. TIME_BITS sets the width of the
// saturating command and repeat timers.
module diff_drive_key_command_latch
  import ddk_pkg::*;
#(
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  ddk_cmd_if.sink             cmd_i,
  ddk_res_if.source           res_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgWidth-1:0] cfg_data_i
);

  cfg_t  cfg;
  item_t in_q;
  logic  in_valid_q;
  res_t  res_d, res_q;
  logic  res_valid_q;
  logic  advance, step;

  ddk_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Advance the pipe whenever the result slot is free or being drained
  assign advance     = !res_valid_q || res_o.ready;
  assign step        = advance && in_valid_q;
  assign cmd_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      in_valid_q <= cmd_i.valid;
    end
  end

  // Capture payload on each accepted transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      in_q.op         <= cmd_i.op;
      in_q.key_char   <= cmd_i.key_char;
      in_q.move_left  <= cmd_i.move_left;
      in_q.move_right <= cmd_i.move_right;
    end
  end

  ddk_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= in_valid_q;
    end
  end

  // Hold the result while the sink stalls
  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid           = res_valid_q;
  assign res_o.left_direction  = res_q.left_direction;
  assign res_o.left_duty       = res_q.left_duty;
  assign res_o.right_direction = res_q.right_direction;
  assign res_o.right_duty      = res_q.right_duty;
  assign res_o.drive_active    = res_q.drive_active;
  assign res_o.speed_forward   = res_q.speed_forward;
  assign res_o.speed_turn      = res_q.speed_turn;
  assign res_o.latch_code      = res_q.latch_code;
  assign res_o.watchdog_fired  = res_q.watchdog_fired;

endmodule
